[sv/psrw_pkg.sv]
// ----------------------------------------------------------------------------
// psrw_pkg
// Shared types and constants of the per-source replay window unit.
// ----------------------------------------------------------------------------
package psrw_pkg;

  localparam int unsigned SrcW   = 8;
  localparam int unsigned NonceW = 64;

  typedef enum logic [1:0] {
    VERDICT_OK    = 2'd0,
    VERDICT_RANGE = 2'd1,
    VERDICT_OLD   = 2'd2,
    VERDICT_DUP   = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd;
    logic cmp;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } ctl_sts_t;

endpackage

[sv/psrw_in_if.sv]
// ----------------------------------------------------------------------------
// psrw_in_if
// Input channel: one word per authenticated packet.
// ----------------------------------------------------------------------------
interface psrw_in_if;
  logic                         valid;
  logic                         ready;
  logic [psrw_pkg::SrcW-1:0]   source_id;
  logic [psrw_pkg::NonceW-1:0] nonce_value;

  modport source (output valid, output source_id, output nonce_value, input ready);
  modport sink (input valid, input source_id, input nonce_value, output ready);
endinterface

[sv/psrw_out_if.sv]
// ----------------------------------------------------------------------------
// psrw_out_if
// Output channel: one verdict word per packet.
// ----------------------------------------------------------------------------
interface psrw_out_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic [1:0] verdict;

  modport source (output valid, output accept, output verdict, input ready);
  modport sink (input valid, input accept, input verdict, output ready);
endinterface

[sv/psrw_ctrl.sv]
// ----------------------------------------------------------------------------
// psrw_ctrl
// Sequencer that walks one packet through read, compare and update.
// ----------------------------------------------------------------------------
module psrw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psrw_pkg::ctl_sts_t sts_i,
  output psrw_pkg::ctl_cmd_t cmd_o
);

  psrw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psrw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      psrw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = psrw_pkg::ST_READ;
        end
      end
      psrw_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = psrw_pkg::ST_CMP;
      end
      psrw_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = psrw_pkg::ST_UPD;
      end
      psrw_pkg::ST_UPD: begin
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = psrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = psrw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/psrw_dp.sv]
// ----------------------------------------------------------------------------
// psrw_dp
// Window table, compare and bitmap update, and the result register.
// ----------------------------------------------------------------------------
module psrw_dp #(
  parameter int unsigned NUM_SOURCES = 256,
  parameter int unsigned WINDOW_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [psrw_pkg::SrcW-1:0]   src_i,
  input  logic [psrw_pkg::NonceW-1:0] nonce_i,
  input  psrw_pkg::ctl_cmd_t           cmd_i,
  output psrw_pkg::ctl_sts_t           sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_accept_o,
  output logic [1:0]                   out_verdict_o
);

  localparam int unsigned IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned ShW  = $clog2(WINDOW_BITS);
  localparam int unsigned NW   = psrw_pkg::NonceW;

  logic [NW-1:0]          hi_mem [NUM_SOURCES];
  logic [WINDOW_BITS-1:0] bm_mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] armed_q;

  logic [IdxW-1:0]        idx_q;
  logic                   in_range_q;
  logic [NW-1:0]          nonce_q;
  logic [NW-1:0]          hi_q;
  logic [WINDOW_BITS-1:0] bm_q;
  logic                   armed_rd_q;
  logic                   ahead_q;
  logic [NW-1:0]          dist_q;

  logic                   out_valid_q;
  logic                   accept_q;
  psrw_pkg::verdict_e     verdict_q;

  logic                   far;
  logic [ShW-1:0]         sh;
  logic [WINDOW_BITS-1:0] bit_sel;
  psrw_pkg::verdict_e     verdict;
  logic                   wr_en;
  logic [NW-1:0]          hi_wr;
  logic [WINDOW_BITS-1:0] bm_wr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q      <= src_i[IdxW-1:0];
      in_range_q <= ({1'b0, src_i} < (psrw_pkg::SrcW + 1)'(NUM_SOURCES));
      nonce_q    <= nonce_i;
    end
    if (cmd_i.rd) begin
      hi_q       <= hi_mem[idx_q];
      bm_q       <= bm_mem[idx_q];
      armed_rd_q <= armed_q[idx_q];
    end
    if (cmd_i.cmp) begin
      ahead_q <= (nonce_q > hi_q);
      dist_q  <= (nonce_q > hi_q) ? (nonce_q - hi_q) : (hi_q - nonce_q);
    end
  end

  always_comb begin
    far     = (dist_q >= NW'(WINDOW_BITS));
    sh      = dist_q[ShW-1:0];
    bit_sel = WINDOW_BITS'(1) << sh;
    verdict = psrw_pkg::VERDICT_OK;
    wr_en   = 1'b0;
    hi_wr   = hi_q;
    bm_wr   = bm_q;
    if (!in_range_q) begin
      verdict = psrw_pkg::VERDICT_RANGE;
    end else if (!armed_rd_q) begin
      wr_en = 1'b1;
      hi_wr = nonce_q;
      bm_wr = WINDOW_BITS'(1);
    end else if (ahead_q) begin
      wr_en = 1'b1;
      hi_wr = nonce_q;
      bm_wr = (far ? '0 : (bm_q << sh)) | WINDOW_BITS'(1);
    end else if (far) begin
      verdict = psrw_pkg::VERDICT_OLD;
    end else if ((bm_q & bit_sel) != '0) begin
      verdict = psrw_pkg::VERDICT_DUP;
    end else begin
      wr_en = 1'b1;
      bm_wr = bm_q | bit_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      hi_mem[idx_q] <= hi_wr;
      bm_mem[idx_q] <= bm_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && wr_en) begin
        armed_q[idx_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      accept_q  <= (verdict == psrw_pkg::VERDICT_OK);
      verdict_q <= verdict;
    end
  end

  assign sts_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_accept_o    = accept_q;
  assign out_verdict_o   = verdict_q;

`ifndef SYNTHESIS
  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && wr_en |-> in_range_q)
    else $error("table written for a source outside the table");

  a_accept_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (accept_q == (verdict_q == psrw_pkg::VERDICT_OK)))
    else $error("accept flag disagrees with verdict");

  a_armed_after_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && wr_en |=> armed_q[$past(idx_q)])
    else $error("entry not armed after an update");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while a word waits");
`endif

endmodule

[sv/per_source_replay_window_unit.sv]
// ----------------------------------------------------------------------------
// per_source_replay_window_unit
// Per-source anti-replay window: accepts or rejects each packet nonce.
// ----------------------------------------------------------------------------
//   Channel | Dir | Payload
//   in_i    | in  | source_id[7:0], nonce_value[63:0]
//   out_o   | out | accept, verdict[1:0]
//
// Each packet passes through four steps: accept, table read, nonce compare and update.
// The single read-modify-write of the window table sets these steps.
// The armed flags clear at reset; the nonce and bitmap table needs no clearing.
// A waiting result holds the update step until the result word is taken.
// ----------------------------------------------------------------------------
module per_source_replay_window_unit #(
  parameter int unsigned NUM_SOURCES = 256,
  parameter int unsigned WINDOW_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psrw_in_if.sink    in_i,
  psrw_out_if.source out_o
);

  psrw_pkg::ctl_cmd_t cmd;
  psrw_pkg::ctl_sts_t sts;

  psrw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psrw_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .src_i         (in_i.source_id),
    .nonce_i       (in_i.nonce_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_accept_o  (out_o.accept),
    .out_verdict_o (out_o.verdict)
  );

endmodule
